// ----- rtl/fpa_pkg.sv -----
`timescale 1ns / 1ps
package fpa_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned DefaultFracBits = 8;

  typedef enum logic [3:0] {
    OpAdd   = 4'd0,
    OpSub   = 4'd1,
    OpMul   = 4'd2,
    OpDiv   = 4'd3,
    OpMin   = 4'd4,
    OpMax   = 4'd5,
    OpInc   = 4'd6,
    OpDec   = 4'd7,
    OpItoF  = 4'd8,
    OpFtoI  = 4'd9
  } op_e;

  // Request context that rides alongside the divider row.
  typedef struct packed {
    logic                   valid;
    logic                   is_div;
    logic                   div_zero;
    logic                   q_neg;
    logic [DataWidth-1:0]   result;
    logic                   gt;
    logic                   lt;
    logic                   eq;
  } ctx_t;

endpackage

// ----- rtl/fpa_div_cell.sv -----
`timescale 1ns / 1ps
// One restoring-division step: brings in one dividend bit and settles one quotient bit.
module fpa_div_cell #(
  parameter int unsigned DW = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fpa_pkg::ctx_t     ctx_i,
  input  logic [DW-1:0]     rem_i,
  input  logic [DW-1:0]     num_i,
  input  logic [DW-1:0]     den_i,
  output fpa_pkg::ctx_t     ctx_o,
  output logic [DW-1:0]     rem_o,
  output logic [DW-1:0]     num_o,
  output logic [DW-1:0]     den_o
);

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic [DW-1:0] rem_d;
  logic [DW-1:0] num_d;
  logic          valid_q;
  fpa_pkg::ctx_t ctx_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] num_q;
  logic [DW-1:0] den_q;

  always_comb begin
    trial = {rem_i, num_i[DW-1]};
    diff  = trial - {1'b0, den_i};
    if (!diff[DW]) begin
      rem_d = diff[DW-1:0];
      num_d = {num_i[DW-2:0], 1'b1};
    end else begin
      rem_d = trial[DW-1:0];
      num_d = {num_i[DW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    ctx_q <= ctx_i;
    rem_q <= rem_d;
    num_q <= num_d;
    den_q <= den_i;
  end

  always_comb begin
    ctx_o       = ctx_q;
    ctx_o.valid = valid_q;
  end

  assign rem_o = rem_q;
  assign num_o = num_q;
  assign den_o = den_q;

endmodule

// ----- rtl/fpa_front.sv -----
`timescale 1ns / 1ps
// Registered front stage: operand decode, the operations other than multiply and divide,
// the multiplier (32x32, registered), plus divider operand preparation.
module fpa_front #(
  parameter int unsigned FracBits = fpa_pkg::DefaultFracBits
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            req_i,
  input  logic [3:0]                      req_type_i,
  input  logic signed [fpa_pkg::DataWidth-1:0] operand_a_i,
  input  logic signed [fpa_pkg::DataWidth-1:0] operand_b_i,
  output fpa_pkg::ctx_t                   ctx_o,
  output logic [2*fpa_pkg::DataWidth-1:0] prod_o,
  output logic                            is_mul_o,
  output logic [2*fpa_pkg::DataWidth-1:0] num_o,
  output logic [2*fpa_pkg::DataWidth-1:0] den_o
);

  localparam int unsigned W  = fpa_pkg::DataWidth;
  localparam int unsigned W2 = 2 * W;

  fpa_pkg::ctx_t ctx_d, ctx_q;
  logic          valid_q;
  logic signed [W2-1:0] prod_d;
  logic [W2-1:0] prod_q;
  logic          is_mul_q;
  logic [W2-1:0] num_d, num_q;
  logic [W2-1:0] den_d, den_q;
  logic [W2-1:0] a_ext;
  logic [W2-1:0] dvd;
  logic [W-1:0]  ua, ub;
  logic [W-1:0]  b_mag;

  always_comb begin
    ua = operand_a_i;
    ub = operand_b_i;
    a_ext = {{W{operand_a_i[W-1]}}, ua};
    dvd = a_ext << FracBits;
    num_d = dvd[W2-1] ? (~dvd + W2'(1)) : dvd;
    b_mag = operand_b_i[W-1] ? (~ub + W'(1)) : ub;
    den_d = {{W{1'b0}}, b_mag};
    prod_d = W2'(operand_a_i) * W2'(operand_b_i);

    ctx_d = '0;
    ctx_d.valid = req_i;
    ctx_d.gt = operand_a_i > operand_b_i;
    ctx_d.lt = operand_a_i < operand_b_i;
    ctx_d.eq = operand_a_i == operand_b_i;
    ctx_d.q_neg = dvd[W2-1] ^ operand_b_i[W-1];
    case (req_type_i)
      fpa_pkg::OpAdd:  ctx_d.result = ua + ub;
      fpa_pkg::OpSub:  ctx_d.result = ua - ub;
      fpa_pkg::OpDiv: begin
        ctx_d.is_div   = 1'b1;
        ctx_d.div_zero = (ub == '0);
      end
      fpa_pkg::OpMin:  ctx_d.result = ctx_d.lt ? ua : ub;
      fpa_pkg::OpMax:  ctx_d.result = ctx_d.gt ? ua : ub;
      fpa_pkg::OpInc:  ctx_d.result = ua + W'(1);
      fpa_pkg::OpDec:  ctx_d.result = ua - W'(1);
      fpa_pkg::OpItoF: ctx_d.result = ua << FracBits;
      fpa_pkg::OpFtoI: ctx_d.result = W'(operand_a_i >>> FracBits);
      default:         ctx_d.result = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctx_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    ctx_q    <= ctx_d;
    prod_q   <= prod_d;
    is_mul_q <= (req_type_i == fpa_pkg::OpMul);
    num_q    <= num_d;
    den_q    <= den_d;
  end

  always_comb begin
    ctx_o       = ctx_q;
    ctx_o.valid = valid_q;
  end

  assign prod_o   = prod_q;
  assign is_mul_o = is_mul_q;
  assign num_o    = num_q;
  assign den_o    = den_q;

endmodule

// ----- rtl/fixed_point_alu.sv -----
`timescale 1ns / 1ps
// Channel  | Handshake           | Payload
// request  | start / busy        | req_type_i, operand_a_i, operand_b_i
// result   | done_o (strobe)     | result_value_o, a_greater_o, a_less_o, a_equal_o,
//          |                     | divide_by_zero_o
//
// A request is taken every cycle; busy is tied low. Every request, whatever
// its opcode, passes one front register, the row of 64 restoring-division
// cells (for 32-bit data) that all requests pass, and one output register
// before its result appears.
// Reset clears only the valid bits of the front, the row and done_o. The receiver
// cannot stall, so results are never held.
module fixed_point_alu #(
  parameter int unsigned FracBits = fpa_pkg::DefaultFracBits
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [3:0]                           req_type_i,
  input  logic signed [fpa_pkg::DataWidth-1:0] operand_a_i,
  input  logic signed [fpa_pkg::DataWidth-1:0] operand_b_i,
  output logic                                 done_o,
  output logic signed [fpa_pkg::DataWidth-1:0] result_value_o,
  output logic                                 a_greater_o,
  output logic                                 a_less_o,
  output logic                                 a_equal_o,
  output logic                                 divide_by_zero_o
);

  localparam int unsigned W  = fpa_pkg::DataWidth;
  localparam int unsigned W2 = 2 * W;

  fpa_pkg::ctx_t ctx_c [W2+1];
  logic [W2-1:0] rem_c [W2+1];
  logic [W2-1:0] num_c [W2+1];
  logic [W2-1:0] den_c [W2+1];

  logic [W2-1:0] prod_q;
  logic          is_mul_q;
  logic [W2-1:0] prod_sh_q;
  logic [W-1:0]  mul_res;

  assign busy = 1'b0;

  fpa_front #(.FracBits(FracBits)) u_front (
    .clk_i, .rst_ni,
    .req_i       (start),
    .req_type_i,
    .operand_a_i,
    .operand_b_i,
    .ctx_o       (ctx_c[0]),
    .prod_o      (prod_q),
    .is_mul_o    (is_mul_q),
    .num_o       (num_c[0]),
    .den_o       (den_c[0])
  );
  assign rem_c[0] = '0;

  // The multiply result is folded into the context after one register.
  logic mul_pend_q;
  always_ff @(posedge clk_i) begin
    prod_sh_q  <= $signed(prod_q) >>> FracBits;
    mul_pend_q <= is_mul_q;
  end

  fpa_pkg::ctx_t ctx1;
  always_comb begin
    ctx1 = ctx_c[1];
    if (mul_pend_q) ctx1.result = prod_sh_q[W-1:0];
  end
  assign mul_res = prod_sh_q[W-1:0];

  for (genvar i = 0; i < W2; i++) begin : g_row
    fpa_div_cell #(.DW(W2)) u_cell (
      .clk_i, .rst_ni,
      .ctx_i (i == 1 ? ctx1 : ctx_c[i]),
      .rem_i (rem_c[i]),
      .num_i (num_c[i]),
      .den_i (den_c[i]),
      .ctx_o (ctx_c[i+1]),
      .rem_o (rem_c[i+1]),
      .num_o (num_c[i+1]),
      .den_o (den_c[i+1])
    );
  end

  fpa_pkg::ctx_t last;
  logic [W-1:0]  quo;
  logic          done_q;
  logic [W-1:0]  res_q;
  logic          gt_q, lt_q, eq_q, dz_q;

  always_comb begin
    last = ctx_c[W2];
    quo  = last.q_neg ? (~num_c[W2][W-1:0] + W'(1)) : num_c[W2][W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= last.is_div ? (last.div_zero ? '0 : quo) : last.result;
    dz_q  <= last.is_div & last.div_zero;
    gt_q  <= last.gt;
    lt_q  <= last.lt;
    eq_q  <= last.eq;
  end

  assign done_o           = done_q;
  assign result_value_o   = res_q;
  assign a_greater_o      = gt_q;
  assign a_less_o         = lt_q;
  assign a_equal_o        = eq_q;
  assign divide_by_zero_o = dz_q;

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $onehot({a_greater_o, a_less_o, a_equal_o}))
    else $error("compare flags not exclusive");
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && divide_by_zero_o) |-> (result_value_o == '0))
    else $error("divide by zero result not zero");
  a_mul_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_pend_q |-> ctx1.result == mul_res)
    else $error("multiply result not merged");

endmodule
